@@ sv/mono_framebuffer_line_drawer_defines.svh @@
// Assertion macros used by the checker file.
`ifndef MONO_FRAMEBUFFER_LINE_DRAWER_DEFINES_SVH
`define MONO_FRAMEBUFFER_LINE_DRAWER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MFLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Next-cycle implication checked outside reset.
`define MFLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`endif

@@ sv/mfld_pkg.sv @@
// ----------------------------------------------------------------------------
// mfld_pkg
// Shared types and codes for the framebuffer line drawer.
// ----------------------------------------------------------------------------
`default_nettype none
package mfld_pkg;
    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_PIXEL  = 3'd1,
        OP_LINE   = 3'd2,
        OP_DOTTED = 3'd3,
        OP_RECT   = 3'd4,
        OP_FILL   = 3'd5,
        OP_READ   = 3'd6,
        OP_NONE   = 3'd7
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LSETUP,
        ST_LSTEP,
        ST_DIV,
        ST_ADDR,
        ST_MOD,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_NEXT,
        ST_READ,
        ST_READ2,
        ST_OUT,
        ST_INIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       capture;     // latch input item
        logic       clr_start;   // begin clear sweep
        logic       clr_step;    // write zero, advance clear address
        logic [1:0] seg_sel;     // which segment to load
        logic       seg_load;    // load line endpoints for segment
        logic       step_init;   // set up major/minor stepping
        logic       div_start;   // begin division
        logic       div_step;    // one division iteration
        logic       addr_calc;   // compute linear byte address
        logic       mod_step;    // wrap address by one store size
        logic       mem_rd;      // issue read of pixel byte
        logic       mem_wr;      // write modified byte
        logic       step_adv;    // advance major coordinate
        logic       col_adv;     // next fill column
        logic       rd_issue;    // read byte opcode
        logic       rd_latch;    // capture read data
        logic       out_clear;   // zero result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        opcode_t    op;
        logic       clr_done;
        logic       div_done;
        logic       mod_done;
        logic       last_step;
        logic       last_col;
        logic       rd_valid_addr;
    } stat_t;
endpackage
`default_nettype wire

@@ sv/mfld_ram.sv @@
// ----------------------------------------------------------------------------
// mfld_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mfld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ sv/mfld_ctrl.sv @@
// ----------------------------------------------------------------------------
// mfld_ctrl
// Command sequencer: walks each opcode through the datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none
module mfld_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire mfld_pkg::stat_t st,
    output mfld_pkg::cmd_t      cmd
);
    mfld_pkg::state_t state_reg, state_next;
    logic [1:0] seg_reg, seg_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfld_pkg::ST_INIT;
            seg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        seg_next    = seg_reg;
        cmd         = '0;
        cmd.seg_sel = seg_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        unique case (state_reg)
            mfld_pkg::ST_INIT:
            begin
                // zero the store after reset
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = mfld_pkg::ST_IDLE;
                end
            end
            mfld_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mfld_pkg::ST_LSETUP;
                end
            end
            mfld_pkg::ST_LSETUP:
            begin
                // decode opcode just latched
                cmd.out_clear = 1'b1;
                seg_next      = '0;
                unique case (st.op) inside
                    mfld_pkg::OP_CLEAR:
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = mfld_pkg::ST_CLEAR;
                    end
                    mfld_pkg::OP_PIXEL, mfld_pkg::OP_LINE, mfld_pkg::OP_DOTTED,
                    mfld_pkg::OP_RECT, mfld_pkg::OP_FILL:
                    begin
                        cmd.seg_sel  = '0;
                        cmd.seg_load = 1'b1;
                        state_next   = mfld_pkg::ST_LSTEP;
                    end
                    mfld_pkg::OP_READ:
                    begin
                        state_next = mfld_pkg::ST_READ;
                    end
                    default:
                    begin
                        state_next = mfld_pkg::ST_OUT;
                    end
                endcase
            end
            mfld_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = mfld_pkg::ST_OUT;
                end
            end
            mfld_pkg::ST_LSTEP:
            begin
                cmd.step_init = 1'b1;
                state_next    = mfld_pkg::ST_DIV;
            end
            mfld_pkg::ST_DIV:
            begin
                if (!st.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    state_next = mfld_pkg::ST_ADDR;
                end
            end
            mfld_pkg::ST_ADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = mfld_pkg::ST_MOD;
            end
            mfld_pkg::ST_MOD:
            begin
                // wrap the byte address into the store
                if (!st.mod_done)
                begin
                    cmd.mod_step = 1'b1;
                end
                else
                begin
                    state_next = mfld_pkg::ST_RMW_RD;
                end
            end
            mfld_pkg::ST_RMW_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = mfld_pkg::ST_RMW_WR;
            end
            mfld_pkg::ST_RMW_WR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = mfld_pkg::ST_NEXT;
            end
            mfld_pkg::ST_NEXT:
            begin
                if (!st.last_step)
                begin
                    cmd.step_adv  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = mfld_pkg::ST_DIV;
                end
                else if (st.op == mfld_pkg::OP_RECT && seg_reg != 2'd3)
                begin
                    seg_next     = seg_reg + 2'd1;
                    cmd.seg_sel  = seg_reg + 2'd1;
                    cmd.seg_load = 1'b1;
                    state_next   = mfld_pkg::ST_LSTEP;
                end
                else if (st.op == mfld_pkg::OP_FILL && !st.last_col)
                begin
                    cmd.col_adv = 1'b1;
                    state_next  = mfld_pkg::ST_LSTEP;
                end
                else
                begin
                    state_next = mfld_pkg::ST_OUT;
                end
            end
            mfld_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = mfld_pkg::ST_READ2;
            end
            mfld_pkg::ST_READ2:
            begin
                cmd.rd_latch = 1'b1;
                state_next   = mfld_pkg::ST_OUT;
            end
            mfld_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = mfld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfld_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ sv/mfld_datapath.sv @@
// ----------------------------------------------------------------------------
// mfld_datapath
// Line stepping, restoring divider, address math and framebuffer access.
// ----------------------------------------------------------------------------
`default_nettype none
module mfld_datapath #(
    parameter int SCREEN_WIDTH = 192,
    parameter int STORE_BYTES  = 1536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [2:0]  opcode,
    input  wire logic [7:0]  start_x,
    input  wire logic [7:0]  start_y,
    input  wire logic [7:0]  end_x,
    input  wire logic [7:0]  end_y,
    input  wire logic [10:0] read_address,
    output logic      [7:0]  read_data,
    input  wire mfld_pkg::cmd_t cmd,
    output mfld_pkg::stat_t  st
);
    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = $clog2(STORE_BYTES / 8 + 1) + 9;

    // latched item
    mfld_pkg::opcode_t op_reg;
    logic [7:0]  sx_reg, sy_reg, ex_reg, ey_reg;
    logic [10:0] ra_reg;
    // current segment, ordered by major axis
    logic [7:0]  a0_reg, a1_reg;        // major start/end
    logic [7:0]  b0_reg;                // minor start
    logic [7:0]  bd_reg;                // minor delta magnitude
    logic        bneg_reg;              // minor delta negative
    logic [7:0]  ad_reg;                // major delta
    logic        xmaj_reg;
    logic        single_reg;
    logic [7:0]  i_reg;                 // major offset
    logic [7:0]  col_reg;
    logic [7:0]  colhi_reg;
    // divider
    logic [15:0] num_reg;
    logic [7:0]  quo_reg;
    logic [7:0]  rem_reg;
    logic [4:0]  dcnt_reg;
    // memory
    logic [PW-1:0] lin_reg;
    logic [2:0]    bit_reg;
    logic [AW:0]   clr_reg;
    logic [7:0]    rdata;
    logic          we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    wdata;

    // segment endpoints selected from the item
    logic [7:0] px0, py0, px1, py1;
    always_comb
    begin
        px0 = sx_reg; py0 = sy_reg; px1 = ex_reg; py1 = ey_reg;
        if (op_reg == mfld_pkg::OP_PIXEL)
        begin
            px1 = sx_reg; py1 = sy_reg;
        end
        else if (op_reg == mfld_pkg::OP_FILL)
        begin
            // next column is loaded while the column counter advances
            px0 = cmd.col_adv ? col_reg + 8'd1 : col_reg;
            px1 = px0;
        end
        else if (op_reg == mfld_pkg::OP_RECT)
        begin
            case (cmd.seg_sel)
                2'd0:    begin px0 = sx_reg; py0 = sy_reg; px1 = sx_reg; py1 = ey_reg; end
                2'd1:    begin px0 = ex_reg; py0 = sy_reg; px1 = ex_reg; py1 = ey_reg; end
                2'd2:    begin px0 = sx_reg; py0 = sy_reg; px1 = ex_reg; py1 = sy_reg; end
                default: begin px0 = sx_reg; py0 = ey_reg; px1 = ex_reg; py1 = ey_reg; end
            endcase
        end
    end

    logic [7:0] adx, ady;
    logic       xm, sw;
    logic [7:0] na0, na1, nb0, nb1;
    always_comb
    begin
        adx = (px0 > px1) ? px0 - px1 : px1 - px0;
        ady = (py0 > py1) ? py0 - py1 : py1 - py0;
        xm  = adx > ady;
        sw  = xm ? (px1 < px0) : (py1 < py0);
        na0 = xm ? (sw ? px1 : px0) : (sw ? py1 : py0);
        na1 = xm ? (sw ? px0 : px1) : (sw ? py0 : py1);
        nb0 = xm ? (sw ? py1 : py0) : (sw ? px1 : px0);
        nb1 = xm ? (sw ? py0 : py1) : (sw ? px0 : px1);
    end

    // current point
    logic [7:0] maj, mnr, px, py;
    logic [7:0] qs;
    always_comb
    begin
        maj = a0_reg + i_reg;
        qs  = bneg_reg ? (8'd0 - quo_reg) : quo_reg;
        mnr = single_reg ? b0_reg : b0_reg + qs;
        px  = xmaj_reg ? maj : mnr;
        py  = xmaj_reg ? mnr : maj;
    end

    // linear page address before wrapping into the store
    logic [PW-1:0] lin;
    always_comb
    begin
        lin = PW'(px) + PW'(py[7:3]) * PW'(SCREEN_WIDTH);
    end

    // trial subtraction of the major delta
    logic [8:0] trial;
    always_comb
    begin
        trial = {rem_reg, num_reg[15]} - {1'b0, ad_reg};
    end

    logic [7:0] stride;
    logic [8:0] nexti;
    always_comb
    begin
        stride = (op_reg == mfld_pkg::OP_DOTTED) ? 8'd2 : 8'd1;
        nexti  = {1'b0, i_reg} + {1'b0, stride};
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= mfld_pkg::opcode_t'(opcode);
            sx_reg <= start_x; sy_reg <= start_y;
            ex_reg <= end_x;   ey_reg <= end_y;
            ra_reg <= read_address;
            col_reg   <= (start_x < end_x) ? start_x : end_x;
            colhi_reg <= (start_x < end_x) ? end_x : start_x;
        end
        if (cmd.col_adv)
        begin
            col_reg <= col_reg + 8'd1;
        end
        if (cmd.seg_load || cmd.col_adv)
        begin
            a0_reg     <= na0;
            a1_reg     <= na1;
            b0_reg     <= nb0;
            ad_reg     <= na1 - na0;
            bneg_reg   <= nb1 < nb0;
            bd_reg     <= (nb1 < nb0) ? nb0 - nb1 : nb1 - nb0;
            xmaj_reg   <= xm;
            single_reg <= (px0 == px1) && (py0 == py1);
        end
        if (cmd.step_init)
        begin
            i_reg <= '0;
        end
        if (cmd.step_adv)
        begin
            i_reg <= nexti[7:0];
        end
        // restoring division |db|*i / ad, 16 iterations
        if (cmd.step_init || cmd.div_start)
        begin
            num_reg  <= 16'(bd_reg) * 16'(cmd.step_init ? 8'd0 : nexti[7:0]);
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= {num_reg[14:0], 1'b0};
            dcnt_reg <= dcnt_reg + 5'd1;
            if (!trial[8] && ad_reg != 8'd0)
            begin
                rem_reg <= trial[7:0];
                quo_reg <= {quo_reg[6:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[6:0], num_reg[15]};
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
        end
        // byte address, then one store size off per cycle until it fits
        if (cmd.addr_calc)
        begin
            lin_reg <= lin;
            bit_reg <= py[2:0];
        end
        else if (cmd.mod_step)
        begin
            lin_reg <= lin_reg - PW'(STORE_BYTES);
        end
        if (cmd.out_clear)
        begin
            read_data <= '0;
        end
        if (cmd.rd_latch && st.rd_valid_addr)
        begin
            read_data <= rdata;
        end
    end

    // clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // memory port select
    always_comb
    begin
        we       = 1'b0;
        ram_addr = lin_reg[AW-1:0];
        wdata    = rdata | (8'd1 << bit_reg);
        if (cmd.clr_step)
        begin
            we       = 1'b1;
            ram_addr = clr_reg[AW-1:0];
            wdata    = '0;
        end
        else if (cmd.mem_wr || cmd.mem_rd)
        begin
            we = cmd.mem_wr;
        end
        else if (cmd.rd_issue)
        begin
            ram_addr = ra_reg[AW-1:0];
        end
    end

    mfld_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (ram_addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // status
    always_comb
    begin
        st.op            = op_reg;
        st.clr_done      = clr_reg == (AW+1)'(STORE_BYTES - 1);
        st.div_done      = single_reg || (dcnt_reg == 5'd16);
        st.mod_done      = lin_reg < PW'(STORE_BYTES);
        st.last_step     = single_reg || (nexti > {1'b0, ad_reg});
        st.last_col      = col_reg == colhi_reg;
        st.rd_valid_addr = {5'd0, ra_reg} < 16'(STORE_BYTES);
    end
endmodule
`default_nettype wire

@@ sv/mono_framebuffer_line_drawer.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_line_drawer
// Drawing engine over a 1-bit page-packed framebuffer.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with opcode, endpoints and read_address.
// Output channel: out_valid/out_stall with read_data, one transfer per item.
// One item is processed at a time; in_stall is high from the input transfer
// until the result transfer, and the next item can be taken in the cycle after it.
// Result path: a read passes decode, read issue and read latch; an unused
// opcode goes from decode to the result; a clear sweeps every store byte first.
// Each plotted point of a line passes a 16-step divider for the minor
// coordinate, up to four page-wrap subtractions at the default sizes, and a
// read-modify-write of the single-port store; a filled rectangle draws one
// such line per column.
// Reset clears the control state, then sweeps zeros through every byte of the
// store one byte a cycle with in_stall high.
// When the receiver stalls, the result holds and no new item is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module mono_framebuffer_line_drawer #(
    parameter int SCREEN_WIDTH = 192,
    parameter int STORE_BYTES  = 1536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [7:0]  start_x,
    input  wire logic [7:0]  start_y,
    input  wire logic [7:0]  end_x,
    input  wire logic [7:0]  end_y,
    input  wire logic [10:0] read_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  read_data
);
    mfld_pkg::cmd_t  cmd;
    mfld_pkg::stat_t st;

    mfld_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
    );

    mfld_datapath #(.SCREEN_WIDTH(SCREEN_WIDTH), .STORE_BYTES(STORE_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .opcode(opcode), .start_x(start_x),
        .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .read_address(read_address), .read_data(read_data), .cmd(cmd), .st(st)
    );
endmodule
`default_nettype wire

@@ sv/mfld_checker.sv @@
// ----------------------------------------------------------------------------
// mfld_checker
// Port-level checks on the drawer's handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mono_framebuffer_line_drawer_defines.svh"
module mfld_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] read_data
);
    `MFLD_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid, in_stall)
    `MFLD_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_data))
    `MFLD_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)
endmodule
bind mono_framebuffer_line_drawer mfld_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data)
);
`default_nettype wire

@@ verif/mono_framebuffer_line_drawer_tb.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_line_drawer_tb
// Self-checking bench: drawing commands are fed over the valid/stall input
// channel and every returned byte is compared with a local framebuffer image.
// ----------------------------------------------------------------------------
`default_nettype none
module mono_framebuffer_line_drawer_tb;
    localparam int SCREEN_W   = 192;
    localparam int FB_BYTES   = 1536;
    localparam int RAND_ITEMS = 800;
    localparam int HOLD_LEN   = 3000;

    typedef struct packed {
        mfld_pkg::opcode_t op;
        logic [7:0]  x1;
        logic [7:0]  y1;
        logic [7:0]  x2;
        logic [7:0]  y2;
        logic [10:0] addr;
    } draw_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
    logic [10:0] read_address;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;

    draw_cmd_t   cmd_queue[$];
    logic [7:0]  pending_bytes[$];
    logic [7:0]  fb_image[FB_BYTES];
    int          n_items;
    int          n_offered;
    int          n_accepted;
    int          n_results;
    int          n_reads;
    int          n_errors;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    bit          hold_done;
    bit          stim_done;

    mono_framebuffer_line_drawer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y), .read_address(read_address),
        .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Framebuffer image
    function automatic void fb_plot(int x, int y);
        int idx;
        idx = ((x & 255) + ((y & 255) >> 3) * SCREEN_W) % FB_BYTES;
        fb_image[idx] |= 8'(1 << (y & 7));
    endfunction

    function automatic void fb_line(int x1, int y1, int x2, int y2, int stride);
        int t;
        int dx;
        int dy;
        if (x1 == x2 && y1 == y2)
        begin
            fb_plot(x1, y1);
            return;
        end
        dx = (x1 > x2) ? x1 - x2 : x2 - x1;
        dy = (y1 > y2) ? y1 - y2 : y2 - y1;
        if (dx > dy)
        begin
            if (x2 < x1)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            for (int i = x1; i <= x2; i += stride)
                fb_plot(i, y1 + (y2 - y1) * (i - x1) / (x2 - x1));
        end
        else
        begin
            if (y2 < y1)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            for (int i = y1; i <= y2; i += stride)
                fb_plot(x1 + (x2 - x1) * (i - y1) / (y2 - y1), i);
        end
    endfunction

    // Apply one command to the image and return the byte it produces
    function automatic logic [7:0] fb_apply(draw_cmd_t c);
        int lo;
        int hi;
        logic [7:0] data;
        data = 8'd0;
        case (c.op)
            mfld_pkg::OP_CLEAR:  foreach (fb_image[i]) fb_image[i] = 8'd0;
            mfld_pkg::OP_PIXEL:  fb_plot(c.x1, c.y1);
            mfld_pkg::OP_LINE:   fb_line(c.x1, c.y1, c.x2, c.y2, 1);
            mfld_pkg::OP_DOTTED: fb_line(c.x1, c.y1, c.x2, c.y2, 2);
            mfld_pkg::OP_RECT:
            begin
                fb_line(c.x1, c.y1, c.x1, c.y2, 1);
                fb_line(c.x2, c.y1, c.x2, c.y2, 1);
                fb_line(c.x1, c.y1, c.x2, c.y1, 1);
                fb_line(c.x1, c.y2, c.x2, c.y2, 1);
            end
            mfld_pkg::OP_FILL:
            begin
                lo = (c.x1 < c.x2) ? c.x1 : c.x2;
                hi = (c.x1 < c.x2) ? c.x2 : c.x1;
                for (int i = lo; i <= hi; i++)
                    fb_line(i, c.y1, i, c.y2, 1);
            end
            mfld_pkg::OP_READ:   if (c.addr < FB_BYTES) data = fb_image[c.addr];
            default: ;
        endcase
        return data;
    endfunction

    function automatic void add_cmd(mfld_pkg::opcode_t op, int x1, int y1, int x2, int y2,
                                    int addr);
        draw_cmd_t c;
        c.op = op; c.x1 = 8'(x1); c.y1 = 8'(y1); c.x2 = 8'(x2); c.y2 = 8'(y2);
        c.addr = 11'(addr);
        cmd_queue.push_back(c);
    endfunction

    // Endpoint near the start, mostly short; wraps now and then into a long span
    function automatic int near_coord(int base, int reach);
        return (base + $urandom_range(0, 2 * reach) - reach) & 255;
    endfunction

    // Stimulus
    initial
    begin
        int x;
        int y;
        int k;
        // store reads as zero after reset
        foreach (fb_image[i]) fb_image[i] = 8'd0;
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, 0);
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, FB_BYTES - 1);
        add_cmd(mfld_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        add_cmd(mfld_pkg::OP_PIXEL, 0, 0, 0, 0, 0);
        add_cmd(mfld_pkg::OP_PIXEL, 255, 255, 0, 0, 0);
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, 0);
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, (255 + 31 * SCREEN_W) % FB_BYTES);
        add_cmd(mfld_pkg::OP_LINE, 10, 3, 10, 3, 0);           // coincident endpoints
        add_cmd(mfld_pkg::OP_LINE, 40, 20, 0, 0, 0);           // reversed, x major
        add_cmd(mfld_pkg::OP_LINE, 5, 5, 12, 12, 0);           // tie goes to y
        add_cmd(mfld_pkg::OP_LINE, 0, 0, 255, 37, 0);          // full width
        add_cmd(mfld_pkg::OP_DOTTED, 30, 9, 2, 1, 0);
        add_cmd(mfld_pkg::OP_DOTTED, 7, 40, 3, 0, 0);
        add_cmd(mfld_pkg::OP_RECT, 20, 30, 3, 17, 0);
        add_cmd(mfld_pkg::OP_FILL, 60, 2, 57, 21, 0);
        add_cmd(mfld_pkg::OP_FILL, 255, 255, 255, 0, 0);       // full-height column
        add_cmd(mfld_pkg::OP_NONE, 255, 255, 255, 255, 2047);
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, 2047);          // beyond the store
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, FB_BYTES);
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, 7);
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, 60);
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, 58 + SCREEN_W);
        add_cmd(mfld_pkg::OP_READ, 0, 0, 0, 0, FB_BYTES - 1);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
            k = $urandom_range(0, 99);
            if (k < 2)
                add_cmd(mfld_pkg::OP_CLEAR, x, y, $urandom, $urandom, $urandom);
            else if (k < 40)
                add_cmd(mfld_pkg::OP_READ, x, y, $urandom, $urandom,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                    : $urandom_range(0, FB_BYTES - 1));
            else if (k < 55)
                add_cmd(mfld_pkg::OP_PIXEL, x, y, $urandom, $urandom, $urandom);
            else if (k < 70)
                add_cmd(mfld_pkg::OP_LINE, x, y, near_coord(x, 20), near_coord(y, 20),
                        $urandom);
            else if (k < 80)
                add_cmd(mfld_pkg::OP_DOTTED, x, y, near_coord(x, 20), near_coord(y, 20),
                        $urandom);
            else if (k < 88)
                add_cmd(mfld_pkg::OP_RECT, x, y, near_coord(x, 10), near_coord(y, 10),
                        $urandom);
            else if (k < 96)
                add_cmd(mfld_pkg::OP_FILL, x, y, near_coord(x, 2), near_coord(y, 10),
                        $urandom);
            else if (k < 98)
                add_cmd(mfld_pkg::OP_LINE, x, y, $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom);
            else
                add_cmd(mfld_pkg::OP_NONE, x, y, $urandom, $urandom, $urandom);
        end
        n_items   = cmd_queue.size();
        stim_done = 1'b1;
    end

    // Input driver: bursts with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            opcode       <= 3'd0;
            start_x      <= 8'd0;
            start_y      <= 8'd0;
            end_x        <= 8'd0;
            end_y        <= 8'd0;
            read_address <= 11'd0;
            burst_left   <= 0;
            gap_left     <= 0;
            n_offered    <= 0;
        end
        else if (!in_valid || n_accepted == n_offered)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmd_queue.size() > 0)
            begin
                draw_cmd_t c;
                c = cmd_queue.pop_front();
                in_valid     <= 1'b1;
                opcode       <= c.op;
                start_x      <= c.x1;
                start_y      <= c.y1;
                end_x        <= c.x2;
                end_y        <= c.y2;
                read_address <= c.addr;
                n_offered    <= n_offered + 1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall pattern, with one long hold-off once traffic is flowing
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && n_accepted >= 100)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if ((n_accepted / 64) % 3 == 1)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 40);
    end

    // Monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            n_accepted <= 0;
            n_results  <= 0;
            n_reads    <= 0;
            n_errors   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                draw_cmd_t c;
                c.op = mfld_pkg::opcode_t'(opcode);
                c.x1 = start_x; c.y1 = start_y; c.x2 = end_x; c.y2 = end_y;
                c.addr = read_address;
                pending_bytes.push_back(fb_apply(c));
                if (c.op == mfld_pkg::OP_READ)
                    n_reads <= n_reads + 1;
                n_accepted <= n_accepted + 1;
            end
            if (out_valid && !out_stall)
            begin
                n_results <= n_results + 1;
                if (pending_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got %02h",
                             $time, read_data);
                    n_errors <= n_errors + 1;
                end
                else
                begin
                    logic [7:0] want;
                    want = pending_bytes.pop_front();
                    if (read_data !== want)
                    begin
                        $display("%0t: read_data mismatch: expected %02h, got %02h",
                                 $time, want, read_data);
                        n_errors <= n_errors + 1;
                    end
                end
            end
        end
    end

    // End of run
    initial
    begin
        @(posedge rst_n);
        wait (stim_done && n_results == n_items);
        repeat (50) @(posedge clk);
        $display("Run covered %0d commands (%0d byte reads) and %0d returned transfers.",
                 n_accepted, n_reads, n_results);
        if (n_errors == 0 && pending_bytes.size() == 0)
            $display("Verification passed");
        else
        begin
            if (pending_bytes.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_bytes.size());
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000000;
        $display("%0t: timeout, %0d results outstanding", $time, pending_bytes.size());
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
